[design/gif_lzw_decompressor_defines.svh]
// Assertion macros for the GIF LZW decoder; only the decode sequencer (glzw_dec) uses them.
`ifndef GIF_LZW_DECOMPRESSOR_DEFINES_SVH
`define GIF_LZW_DECOMPRESSOR_DEFINES_SVH
`ifndef SYNTH
`define GLZW_CHK_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("glzw assertion failed");
`define GLZW_CHK_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("glzw assertion failed");
`else
`define GLZW_CHK_IMPL(lbl, ante, cons)
`define GLZW_CHK_NEXT(lbl, ante, cons)
`endif
`endif

[design/glzw_pkg.sv]
// Types and constants of the GIF LZW decoder.
package glzw_pkg;

	localparam logic [3:0] RESET_MIN_CODE = 4'd8;
	localparam logic REQ_PUSH = 1'b0;
	localparam logic REQ_PULL = 1'b1;

	typedef enum logic [2:0] {
		ST_PIXEL  = 3'd0,
		ST_ACCEPT = 3'd1,
		ST_NEED   = 3'd2,
		ST_END    = 3'd3,
		ST_ERROR  = 3'd4,
		ST_REJECT = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_TAKE,
		S_LINK,
		S_FINISH,
		S_POPW
	} state_t;

	typedef struct packed {
		logic       req_type;
		logic [7:0] in_byte;
	} in_item_t;

	typedef struct packed {
		logic [11:0] pixel_index;
		status_t     status;
	} out_item_t;

	typedef struct packed {
		logic restart;
		logic push;
		logic take;
	} bb_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} dec_stat_t;

endpackage

[design/glzw_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module glzw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[design/glzw_bitbuf.sv]
// Bit buffer that packs data bytes LSB-first and extracts variable-width codes.
module glzw_bitbuf #(
	parameter int TABLE_BITS = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  glzw_pkg::bb_ctl_t     ctl,
	input  logic [7:0]            in_byte,
	input  logic [4:0]            code_width,
	output logic [5:0]            bit_count,
	output logic [TABLE_BITS-1:0] code
);

	logic [31:0] buf_q;
	logic [5:0]  cnt_q;
	logic [31:0] masked;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q <= '0;
			cnt_q <= '0;
		end else if (ctl.restart) begin
			buf_q <= '0;
			cnt_q <= '0;
		end else if (ctl.push) begin
			buf_q <= buf_q | (32'(in_byte) << cnt_q);
			cnt_q <= cnt_q + 6'd8;
		end else if (ctl.take) begin
			buf_q <= buf_q >> code_width;
			cnt_q <= cnt_q - {1'b0, code_width};
		end
	end

	assign masked = buf_q & ~(32'hFFFF_FFFF << code_width);
	assign code = masked[TABLE_BITS-1:0];
	assign bit_count = cnt_q;

endmodule

[design/glzw_dec.sv]
// Decode sequencer: sub-block parsing, code handling, table chain walk and stack.
`include "gif_lzw_decompressor_defines.svh"
module glzw_dec #(
	parameter int TABLE_BITS = 12,
	parameter int STACK_DEPTH = 2048
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  restart,
	input  logic [3:0]            min_code_size,
	input  logic [3:0]            new_min_code_size,
	input  logic                  start,
	input  glzw_pkg::in_item_t    req,
	input  logic [5:0]            bit_count,
	input  logic [TABLE_BITS-1:0] code,
	output logic [4:0]            code_width,
	output glzw_pkg::bb_ctl_t     bb_ctl,
	output glzw_pkg::dec_stat_t   stat,
	output glzw_pkg::out_item_t   result
);

	localparam int TB = TABLE_BITS;
	localparam logic [TB:0] TSIZE = (TB+1)'(1) << TB;
	localparam int SAW = $clog2(STACK_DEPTH);
	localparam int SCW = $clog2(STACK_DEPTH + 1);
	localparam logic [SCW-1:0] SDEPTH = SCW'(STACK_DEPTH);

	glzw_pkg::state_t st_q, st_d;

	logic [SCW-1:0] stack_cnt_q, stack_cnt_d;
	logic [7:0]     subblk_q, subblk_d;
	logic           data_done_q, data_done_d;
	logic [4:0]     cw_q, cw_d;
	logic [TB:0]    next_code_q, next_code_d;
	logic [TB:0]    width_lim_q, width_lim_d;
	logic [TB:0]    hi_q, hi_d;
	logic [TB-1:0]  prev_q, prev_d;
	logic [TB-1:0]  first_q, first_d;
	logic           pending_q, pending_d;
	logic [TB-1:0]  cur_q, cur_d;
	logic [TB-1:0]  incode_q, incode_d;

	logic [TB:0]    clr, rclr, code_x, cur_x, nn;
	logic           have_bits, cfg_bad, stk_room, link_ok, char_ok;
	logic [TB-1:0]  link_rd, lk, walk_v, tab_raddr;
	logic [7:0]     char_rd, ch, fch;
	logic           do_walk, tab_we, stk_we;
	logic [7:0]     stk_wdata, stk_rd;
	logic [SAW-1:0] stk_raddr;
	logic [SCW-1:0] cnt_new, cnt_dec;
	glzw_pkg::out_item_t res_d;
	logic           done_d;

	glzw_ram #(.WIDTH(TB), .DEPTH(1 << TB)) u_link_ram (
		.clk(clk), .we(tab_we), .waddr(next_code_q[TB-1:0]), .wdata(prev_q),
		.raddr(tab_raddr), .rdata(link_rd)
	);

	glzw_ram #(.WIDTH(8), .DEPTH(1 << TB)) u_char_ram (
		.clk(clk), .we(tab_we), .waddr(next_code_q[TB-1:0]), .wdata(fch),
		.raddr(tab_raddr), .rdata(char_rd)
	);

	glzw_ram #(.WIDTH(8), .DEPTH(STACK_DEPTH)) u_stack_ram (
		.clk(clk), .we(stk_we), .waddr(stack_cnt_q[SAW-1:0]), .wdata(stk_wdata),
		.raddr(stk_raddr), .rdata(stk_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= glzw_pkg::S_IDLE;
		end else if (restart) begin
			st_q <= glzw_pkg::S_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		clr = (TB+1)'(1) << min_code_size;
		rclr = (TB+1)'(1) << new_min_code_size;
		code_x = {1'b0, code};
		cur_x = {1'b0, cur_q};
		have_bits = bit_count >= {1'b0, cw_q};
		cfg_bad = {1'b0, min_code_size} >= 5'(TB);
		stk_room = stack_cnt_q < SDEPTH;
		cnt_dec = stack_cnt_q - SCW'(1);
		link_ok = (cur_x >= clr + (TB+1)'(2)) && (cur_x < next_code_q);
		char_ok = (cur_x >= clr + (TB+1)'(2)) && (cur_x < hi_q);
		lk = link_ok ? link_rd : '0;
		ch = char_ok ? char_rd : 8'd0;
		fch = cur_q[7:0];
		nn = next_code_q + (TB+1)'(1);
		cnt_new = stack_cnt_q + SCW'(stk_room);

		st_d = st_q;
		stack_cnt_d = stack_cnt_q;
		subblk_d = subblk_q;
		data_done_d = data_done_q;
		cw_d = cw_q;
		next_code_d = next_code_q;
		width_lim_d = width_lim_q;
		hi_d = hi_q;
		prev_d = prev_q;
		first_d = first_q;
		pending_d = pending_q;
		cur_d = cur_q;
		incode_d = incode_q;
		bb_ctl = '{restart: restart, push: 1'b0, take: 1'b0};
		do_walk = 1'b0;
		walk_v = cur_q;
		tab_raddr = cur_q;
		tab_we = 1'b0;
		stk_we = 1'b0;
		stk_wdata = ch;
		stk_raddr = cnt_dec[SAW-1:0];
		done_d = 1'b0;
		res_d = '{pixel_index: 12'd0, status: glzw_pkg::ST_PIXEL};

		case (st_q)
			glzw_pkg::S_IDLE: begin
				if (start) begin
					if (req.req_type == glzw_pkg::REQ_PUSH) begin
						done_d = 1'b1;
						res_d.status = glzw_pkg::ST_ACCEPT;
						if (data_done_q) begin
							res_d.status = glzw_pkg::ST_REJECT;
						end else if (subblk_q == 8'd0) begin
							if (req.in_byte == 8'd0) begin
								data_done_d = 1'b1;
							end else begin
								subblk_d = req.in_byte;
							end
						end else if (bit_count > 6'd24) begin
							res_d.status = glzw_pkg::ST_REJECT;
						end else begin
							bb_ctl.push = 1'b1;
							subblk_d = subblk_q - 8'd1;
						end
					end else if (stack_cnt_q != '0) begin
						stack_cnt_d = cnt_dec;
						st_d = glzw_pkg::S_POPW;
					end else begin
						st_d = glzw_pkg::S_TAKE;
					end
				end
			end
			glzw_pkg::S_TAKE: begin
				if (pending_q && cfg_bad) begin
					done_d = 1'b1;
					res_d.status = glzw_pkg::ST_ERROR;
					st_d = glzw_pkg::S_IDLE;
				end else if (!have_bits) begin
					done_d = 1'b1;
					res_d.status = data_done_q ? glzw_pkg::ST_ERROR : glzw_pkg::ST_NEED;
					st_d = glzw_pkg::S_IDLE;
				end else begin
					bb_ctl.take = 1'b1;
					if (code_x == clr) begin
						if (!pending_q) begin
							cw_d = {1'b0, min_code_size} + 5'd1;
							width_lim_d = clr << 1;
							next_code_d = clr + (TB+1)'(2);
							stack_cnt_d = '0;
							pending_d = 1'b1;
						end
					end else if (pending_q) begin
						pending_d = 1'b0;
						first_d = code;
						prev_d = code;
						done_d = 1'b1;
						st_d = glzw_pkg::S_IDLE;
						if (code_x == clr + (TB+1)'(1)) begin
							res_d.status = glzw_pkg::ST_END;
						end else begin
							res_d.pixel_index = 12'(code);
						end
					end else if (code_x == clr + (TB+1)'(1)) begin
						done_d = 1'b1;
						res_d.status = glzw_pkg::ST_END;
						st_d = glzw_pkg::S_IDLE;
					end else begin
						incode_d = code;
						do_walk = 1'b1;
						walk_v = code;
						if (code_x >= next_code_q) begin
							walk_v = prev_q;
							stk_wdata = first_q[7:0];
							stk_we = stk_room;
							stack_cnt_d = cnt_new;
						end
					end
				end
			end
			glzw_pkg::S_LINK: begin
				stk_wdata = ch;
				stk_we = stk_room;
				stack_cnt_d = cnt_new;
				if (lk == cur_q || cnt_new >= SDEPTH) begin
					done_d = 1'b1;
					res_d.pixel_index = 12'(cur_q);
					st_d = glzw_pkg::S_IDLE;
				end else begin
					do_walk = 1'b1;
					walk_v = lk;
				end
			end
			glzw_pkg::S_FINISH: begin
				first_d = TB'(fch);
				prev_d = incode_q;
				if (next_code_q < TSIZE) begin
					tab_we = 1'b1;
					next_code_d = nn;
					if (nn > hi_q) begin
						hi_d = nn;
					end
					if (nn >= width_lim_q && width_lim_q < TSIZE) begin
						width_lim_d = width_lim_q << 1;
						cw_d = cw_q + 5'd1;
					end
				end
				if (stk_room) begin
					done_d = 1'b1;
					res_d.pixel_index = 12'(fch);
					st_d = glzw_pkg::S_IDLE;
				end else begin
					stack_cnt_d = cnt_dec;
					st_d = glzw_pkg::S_POPW;
				end
			end
			glzw_pkg::S_POPW: begin
				done_d = 1'b1;
				res_d.pixel_index = 12'(stk_rd);
				st_d = glzw_pkg::S_IDLE;
			end
			default: begin
				st_d = glzw_pkg::S_IDLE;
			end
		endcase

		if (do_walk) begin
			cur_d = walk_v;
			tab_raddr = walk_v;
			st_d = ({1'b0, walk_v} >= clr) ? glzw_pkg::S_LINK : glzw_pkg::S_FINISH;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stack_cnt_q <= '0;
			subblk_q <= '0;
			data_done_q <= 1'b0;
			cw_q <= 5'd9;
			next_code_q <= (TB+1)'(258);
			width_lim_q <= (TB+1)'(512);
			hi_q <= (TB+1)'(258);
			prev_q <= '0;
			first_q <= '0;
			pending_q <= 1'b1;
			cur_q <= '0;
			incode_q <= '0;
		end else if (restart) begin
			stack_cnt_q <= '0;
			subblk_q <= '0;
			data_done_q <= 1'b0;
			cw_q <= {1'b0, new_min_code_size} + 5'd1;
			next_code_q <= rclr + (TB+1)'(2);
			width_lim_q <= rclr << 1;
			hi_q <= rclr + (TB+1)'(2);
			prev_q <= '0;
			first_q <= '0;
			pending_q <= 1'b1;
			cur_q <= '0;
			incode_q <= '0;
		end else begin
			stack_cnt_q <= stack_cnt_d;
			subblk_q <= subblk_d;
			data_done_q <= data_done_d;
			cw_q <= cw_d;
			next_code_q <= next_code_d;
			width_lim_q <= width_lim_d;
			hi_q <= hi_d;
			prev_q <= prev_d;
			first_q <= first_d;
			pending_q <= pending_d;
			cur_q <= cur_d;
			incode_q <= incode_d;
		end
	end

	assign code_width = cw_q;
	assign stat = '{busy: (st_q != glzw_pkg::S_IDLE), done: done_d};
	assign result = res_d;

	`GLZW_CHK_IMPL(a_done_has_work, done_d, (st_q != glzw_pkg::S_IDLE) || start)
	`GLZW_CHK_IMPL(a_link_above_clear, st_q == glzw_pkg::S_LINK, cur_x >= clr)
	`GLZW_CHK_NEXT(a_pull_leaves_idle,
		start && !restart && st_q == glzw_pkg::S_IDLE && req.req_type,
		st_q != glzw_pkg::S_IDLE)

endmodule

[design/gif_lzw_decompressor.sv]
// Top level of the GIF LZW decoder: configuration register, handshakes, result register.
// A push beat is answered from the idle state; a stack pop passes through a pop-wait state.
// A decoding pull reads codes in the take state, which also consumes clear codes and answers
// the first code after a clear, an end code or a lack of bits; any other code walks the
// table chain in the link state, one entry per cycle, and then normally the finish state.
// One item is in work at a time, and a stalled result holds off the next input beat.
// Asynchronous reset clears all control state; the tables need no clearing pass.
module gif_lzw_decompressor #(
	parameter int TABLE_BITS = 12,
	parameter int STACK_DEPTH = 2048
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  glzw_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output glzw_pkg::out_item_t out_data,
	input  logic                cfg_we,
	input  logic [3:0]          cfg_wdata
);

	logic [3:0]            min_code_size_q;
	logic                  out_valid_q;
	glzw_pkg::out_item_t   out_q;
	logic                  start;
	glzw_pkg::bb_ctl_t     bb_ctl;
	glzw_pkg::dec_stat_t   stat;
	glzw_pkg::out_item_t   result;
	logic [5:0]            bit_count;
	logic [TABLE_BITS-1:0] code;
	logic [4:0]            code_width;

	assign in_stall = stat.busy || (out_valid_q && out_stall);
	assign start = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_code_size_q <= glzw_pkg::RESET_MIN_CODE;
		end else if (cfg_we) begin
			min_code_size_q <= cfg_wdata;
		end
	end

	glzw_bitbuf #(.TABLE_BITS(TABLE_BITS)) u_bitbuf (
		.clk(clk), .arst_n(arst_n), .ctl(bb_ctl), .in_byte(in_data.in_byte),
		.code_width(code_width), .bit_count(bit_count), .code(code)
	);

	glzw_dec #(.TABLE_BITS(TABLE_BITS), .STACK_DEPTH(STACK_DEPTH)) u_dec (
		.clk(clk), .arst_n(arst_n), .restart(cfg_we), .min_code_size(min_code_size_q),
		.new_min_code_size(cfg_wdata), .start(start), .req(in_data),
		.bit_count(bit_count), .code(code), .code_width(code_width), .bb_ctl(bb_ctl),
		.stat(stat), .result(result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (stat.done) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.done) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

[tb/sv/gif_lzw_decompressor_tb.sv]
// Self-checking testbench for the GIF LZW decoder: directed table, generated LZW streams.
module gif_lzw_decompressor_tb;

	localparam logic PUSH = glzw_pkg::REQ_PUSH;
	localparam logic PULL = glzw_pkg::REQ_PULL;
	localparam int TBL = 4096;
	localparam int STK = 2048;
	localparam int CYCLE_LIMIT = 20000000;

	typedef struct {
		logic              req;
		logic [7:0]        data;
		bit                typed;
		logic [11:0]       pix;
		glzw_pkg::status_t st;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	glzw_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	glzw_pkg::out_item_t out_data;
	logic cfg_we = 1'b0;
	logic [3:0] cfg_wdata = 4'd0;

	gif_lzw_decompressor dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Decoder state mirrored for prediction.
	logic [11:0] link_tab[TBL];
	logic [7:0] char_tab[TBL];
	logic [7:0] pix_stack[STK];
	int unsigned code_size, stack_cnt, bit_buf, bit_cnt, block_left, data_end;
	int unsigned cur_width, next_entry, grow_at, prev_entry, first_ch, after_clear;

	// Stream generator state.
	int unsigned g_next, g_width, g_limit, g_fresh;
	logic [63:0] pack_acc;
	int pack_n;
	logic [7:0] data_q[$];

	glzw_pkg::out_item_t pixels_due[$];
	glzw_pkg::status_t last_st;
	int errors = 0;
	int phase_items;
	int snd_idle = 0;
	int rcv_idle = 0;
	int cycles = 0;

	function automatic void clear_tables();
		int unsigned clr;
		clr = 1 << code_size;
		for (int i = 0; i < TBL; i++) begin
			link_tab[i] = '0;
			if (i < clr)
				char_tab[i] = i[7:0];
		end
		cur_width = code_size + 1;
		grow_at = clr << 1;
		next_entry = clr + 2;
		stack_cnt = 0;
		after_clear = 1;
	endfunction

	function automatic void restart_decoder(int unsigned sz);
		code_size = sz;
		for (int i = 0; i < TBL; i++)
			char_tab[i] = '0;
		for (int i = 0; i < STK; i++)
			pix_stack[i] = '0;
		clear_tables();
		bit_buf = 0;
		bit_cnt = 0;
		block_left = 0;
		data_end = 0;
		prev_entry = 0;
		first_ch = 0;
		g_next = (1 << sz) + 2;
		g_width = sz + 1;
		g_limit = (1 << sz) << 1;
		g_fresh = 1;
		pack_acc = '0;
		pack_n = 0;
		data_q.delete();
	endfunction

	function automatic int take_code(output int unsigned code);
		code = 0;
		if (cur_width > 16 || bit_cnt < cur_width)
			return data_end ? -1 : 0;
		code = bit_buf & ((32'd1 << cur_width) - 1);
		bit_buf = bit_buf >> cur_width;
		bit_cnt -= cur_width;
		return 1;
	endfunction

	function automatic void stack_char(int unsigned v);
		if (stack_cnt < STK) begin
			pix_stack[stack_cnt] = v[7:0];
			stack_cnt++;
		end
	endfunction

	function automatic glzw_pkg::status_t decode_codes(output logic [11:0] pix);
		int unsigned clr, code, incode, idx;
		int r;
		clr = 1 << code_size;
		pix = '0;
		while (1) begin
			if (after_clear != 0) begin
				if (code_size >= 12)
					return glzw_pkg::ST_ERROR;
				r = take_code(code);
				if (r <= 0)
					return r < 0 ? glzw_pkg::ST_ERROR : glzw_pkg::ST_NEED;
				if (code == clr)
					continue;
				after_clear = 0;
				first_ch = code;
				prev_entry = code;
				if (code == clr + 1)
					return glzw_pkg::ST_END;
				pix = code[11:0];
				return glzw_pkg::ST_PIXEL;
			end
			r = take_code(code);
			if (r <= 0)
				return r < 0 ? glzw_pkg::ST_ERROR : glzw_pkg::ST_NEED;
			if (code == clr) begin
				clear_tables();
				continue;
			end
			if (code == clr + 1)
				return glzw_pkg::ST_END;
			incode = code;
			if (code >= next_entry) begin
				stack_char(first_ch);
				code = prev_entry;
			end
			while (code >= clr) begin
				idx = code & (TBL - 1);
				stack_char(char_tab[idx]);
				if (link_tab[idx] == code || stack_cnt >= STK) begin
					pix = code[11:0];
					return glzw_pkg::ST_PIXEL;
				end
				code = link_tab[idx];
			end
			first_ch = char_tab[code & (TBL - 1)];
			stack_char(first_ch);
			if (next_entry < TBL) begin
				link_tab[next_entry] = prev_entry[11:0];
				char_tab[next_entry] = first_ch[7:0];
				next_entry++;
				if (next_entry >= grow_at && grow_at < TBL) begin
					grow_at <<= 1;
					cur_width++;
				end
			end
			prev_entry = incode & 12'hFFF;
			if (stack_cnt > 0) begin
				stack_cnt--;
				pix = pix_stack[stack_cnt];
			end
			return glzw_pkg::ST_PIXEL;
		end
	endfunction

	function automatic glzw_pkg::out_item_t predict_pixel(glzw_pkg::in_item_t it);
		glzw_pkg::out_item_t res;
		logic [11:0] pix;
		pix = '0;
		if (it.req_type == PUSH) begin
			if (data_end != 0) begin
				res.status = glzw_pkg::ST_REJECT;
			end else if (block_left == 0) begin
				if (it.in_byte == 0)
					data_end = 1;
				else
					block_left = it.in_byte;
				res.status = glzw_pkg::ST_ACCEPT;
			end else if (bit_cnt > 24) begin
				res.status = glzw_pkg::ST_REJECT;
			end else begin
				bit_buf = bit_buf | (32'(it.in_byte) << bit_cnt);
				bit_cnt += 8;
				block_left--;
				res.status = glzw_pkg::ST_ACCEPT;
			end
		end else if (stack_cnt > 0) begin
			stack_cnt--;
			pix = pix_stack[stack_cnt];
			res.status = glzw_pkg::ST_PIXEL;
		end else begin
			res.status = decode_codes(pix);
			if (res.status != glzw_pkg::ST_PIXEL)
				pix = '0;
		end
		res.pixel_index = pix;
		return res;
	endfunction

	task automatic send_beat(glzw_pkg::in_item_t it);
		while ($urandom_range(99) < snd_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
	endtask

	task automatic issue(logic req, logic [7:0] b);
		glzw_pkg::in_item_t it;
		glzw_pkg::out_item_t res;
		it.req_type = req;
		it.in_byte = b;
		res = predict_pixel(it);
		last_st = res.status;
		pixels_due.push_back(res);
		phase_items++;
		send_beat(it);
	endtask

	task automatic feed_byte(logic [7:0] b);
		int n;
		n = 0;
		if (block_left != 0 && data_end == 0)
			while (bit_cnt > 24 && n < 8) begin
				issue(PULL, 8'd0);
				n++;
			end
		issue(PUSH, b);
		repeat ($urandom_range(0, 2))
			issue(PULL, 8'($urandom_range(255)));
	endtask

	task automatic emit_blocks(bit flush);
		int blk;
		while (data_q.size() > 0) begin
			blk = ($urandom_range(9) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 12);
			if (blk > data_q.size()) begin
				if (!flush)
					return;
				blk = data_q.size();
			end
			feed_byte(blk[7:0]);
			repeat (blk)
				feed_byte(data_q.pop_front());
		end
	endtask

	task automatic pack_code(int unsigned code, int unsigned width);
		pack_acc = pack_acc | (64'(code) << pack_n);
		pack_n += width;
		while (pack_n >= 8) begin
			data_q.push_back(pack_acc[7:0]);
			pack_acc = pack_acc >> 8;
			pack_n -= 8;
		end
	endtask

	// Mostly well-formed codes, tracking the width the decoder will read them at.
	task automatic gen_code(int noise_pct);
		int unsigned clr, code, w, top;
		clr = 1 << code_size;
		w = g_width;
		if ($urandom_range(99) < noise_pct) begin
			code = $urandom_range((1 << w) - 1);
		end else if (g_fresh != 0) begin
			code = $urandom_range(clr - 1);
			g_fresh = 0;
		end else if ($urandom_range(99) < 3) begin
			code = clr;
			g_next = clr + 2;
			g_width = code_size + 1;
			g_limit = clr << 1;
			g_fresh = 1;
		end else if ($urandom_range(99) < 2) begin
			code = clr + 1;
		end else begin
			top = (g_next > TBL - 1) ? TBL - 1 : g_next;
			if ($urandom_range(1) == 0 || top < clr + 2)
				code = $urandom_range(clr - 1);
			else
				code = $urandom_range(top, clr + 2);
			if (g_next < TBL) begin
				g_next++;
				if (g_next >= g_limit && g_limit < TBL) begin
					g_limit <<= 1;
					g_width++;
				end
			end
		end
		pack_code(code, w);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pixels_due.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_code_size(logic [3:0] sz);
		wait_drained();
		repeat (30) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= sz;
		@(negedge clk);
		cfg_we <= 1'b0;
		restart_decoder(sz);
	endtask

	task automatic run_stream(logic [3:0] sz, int budget, int noise_pct);
		int n;
		write_code_size(sz);
		phase_items = 0;
		while (phase_items < budget) begin
			gen_code(noise_pct);
			emit_blocks(1'b0);
		end
		if (pack_n > 0)
			pack_code(0, 8 - pack_n);
		emit_blocks(1'b1);
		feed_byte(8'd0);
		n = 0;
		do begin
			issue(PULL, 8'd0);
			n++;
		end while ((last_st == glzw_pkg::ST_PIXEL || last_st == glzw_pkg::ST_END) && n < 5000);
		issue(PUSH, 8'($urandom_range(255)));
	endtask

	task automatic report(string msg);
		$display("mismatch at cycle %0d: %s", cycles, msg);
		errors++;
	endtask

	always @(negedge clk)
		out_stall <= ($urandom_range(99) < rcv_idle);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		glzw_pkg::out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pixels_due.size() == 0) begin
				report($sformatf("unexpected beat %h", out_data));
			end else begin
				want = pixels_due.pop_front();
				if (out_data.status !== want.status)
					report($sformatf("status %0d, expected %0d", out_data.status, want.status));
				if (out_data.pixel_index !== want.pixel_index)
					report($sformatf("pixel_index %0d, expected %0d",
						out_data.pixel_index, want.pixel_index));
			end
		end
	end

	dir_row_t directed[] = '{
		'{PULL, 8'h00, 1, 12'd0, glzw_pkg::ST_NEED},
		'{PUSH, 8'h05, 1, 12'd0, glzw_pkg::ST_ACCEPT},
		'{PUSH, 8'h00, 1, 12'd0, glzw_pkg::ST_ACCEPT},
		'{PUSH, 8'hFF, 1, 12'd0, glzw_pkg::ST_ACCEPT},
		'{PUSH, 8'h00, 1, 12'd0, glzw_pkg::ST_ACCEPT},
		'{PUSH, 8'hFF, 1, 12'd0, glzw_pkg::ST_ACCEPT},
		'{PUSH, 8'hAA, 1, 12'd0, glzw_pkg::ST_REJECT},
		'{PULL, 8'hFF, 0, 12'd0, glzw_pkg::ST_PIXEL},
		'{PULL, 8'h00, 0, 12'd0, glzw_pkg::ST_PIXEL},
		'{PULL, 8'h00, 0, 12'd0, glzw_pkg::ST_PIXEL},
		'{PULL, 8'h00, 0, 12'd0, glzw_pkg::ST_PIXEL},
		'{PUSH, 8'h81, 0, 12'd0, glzw_pkg::ST_ACCEPT},
		'{PULL, 8'h00, 0, 12'd0, glzw_pkg::ST_PIXEL},
		'{PUSH, 8'h00, 1, 12'd0, glzw_pkg::ST_ACCEPT},
		'{PUSH, 8'h12, 1, 12'd0, glzw_pkg::ST_REJECT},
		'{PULL, 8'h00, 0, 12'd0, glzw_pkg::ST_PIXEL},
		'{PULL, 8'h00, 0, 12'd0, glzw_pkg::ST_PIXEL},
		'{PULL, 8'h00, 0, 12'd0, glzw_pkg::ST_PIXEL},
		'{PULL, 8'h00, 0, 12'd0, glzw_pkg::ST_PIXEL}
	};

	initial begin
		glzw_pkg::in_item_t it;
		glzw_pkg::out_item_t res;
		int n;
		restart_decoder(glzw_pkg::RESET_MIN_CODE);
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		snd_idle = 6;
		rcv_idle = 55;
		foreach (directed[i]) begin
			it.req_type = directed[i].req;
			it.in_byte = directed[i].data;
			res = predict_pixel(it);
			if (directed[i].typed) begin
				res.pixel_index = directed[i].pix;
				res.status = directed[i].st;
			end
			pixels_due.push_back(res);
			send_beat(it);
		end
		in_valid <= 1'b0;
		wait_drained();
		run_stream(4'd1, 300, 30);
		run_stream(4'd12, 40, 0);
		snd_idle = 55;
		rcv_idle = 6;
		run_stream(4'd4, 380, 5);
		run_stream(4'd11, 380, 3);
		snd_idle = 0;
		rcv_idle = 0;
		run_stream(4'd2, 330, 5);
		run_stream(glzw_pkg::RESET_MIN_CODE, 330, 2);
		in_valid <= 1'b0;
		n = 0;
		while (pixels_due.size() != 0 && n < 200000) begin
			@(negedge clk);
			n++;
		end
		repeat (50) @(negedge clk);
		if (errors == 0 && pixels_due.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
